// ----- rtl/core/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types and constants for the wavetable sound mixer core.
// ----------------------------------------------------------------------------
package wsm_pkg;

    // Fixed field widths and scale constants.
    localparam int FREQ_W      = 11;
    localparam int DIVISOR_W   = 12;
    localparam int DIVIDEND_W  = 41;
    localparam int SUM_W       = 16;
    localparam int TICK_SCALE  = 278;
    localparam int FREQ_SPAN   = 2048;

    // Request kinds carried in tuser.
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_WAVE   = 3'd1;
    localparam logic [2:0] REQ_FREQ   = 3'd2;
    localparam logic [2:0] REQ_VOLUME = 3'd3;
    localparam logic [2:0] REQ_ENABLE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MASTER_VOLUME = 3'd0;
    localparam logic [2:0] CFG_VOICE_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_SWEEP_ENABLE  = 3'd2;
    localparam logic [2:0] CFG_SWEEP_STEP    = 3'd3;
    localparam logic [2:0] CFG_SWEEP_PERIOD  = 3'd4;

    // Tick sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_ACC,
        ST_MIX
    } t_state;

endpackage

// ----- rtl/core/wsm_div.sv -----
// ----------------------------------------------------------------------------
// wsm_div
// Restoring divider, one quotient bit per cycle. Only the quotient modulo
// the wave length is kept, folded in as each quotient bit appears.
// ----------------------------------------------------------------------------
module wsm_div
    import wsm_pkg::*;
#(
    parameter int WAVE_LEN = 32,
    parameter int IDX_W    = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_index
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [IDX_W-1:0]      r_mod;

    logic [DIVISOR_W:0]    w_rem_sh;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;
    logic [IDX_W:0]        w_mod_sh;
    logic [IDX_W-1:0]      n_mod;

    // One restoring step and the running modulo of the quotient.
    always_comb begin
        w_rem_sh = {r_rem, r_dvd[DIVIDEND_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dvs});
        n_rem    = w_ge ? DIVISOR_W'(w_rem_sh - {1'b0, r_dvs}) : DIVISOR_W'(w_rem_sh);
        w_mod_sh = {r_mod, w_ge};
        if (w_mod_sh >= (IDX_W + 1)'(WAVE_LEN)) begin
            n_mod = IDX_W'(w_mod_sh - (IDX_W + 1)'(WAVE_LEN));
        end else begin
            n_mod = IDX_W'(w_mod_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_mod <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_mod <= n_mod;
        end
    end

    assign o_done  = r_busy && (r_cnt == '0);
    assign o_index = r_mod;

endmodule

// ----- rtl/core/wsm_wave_mem.sv -----
// ----------------------------------------------------------------------------
// wsm_wave_mem
// Wave table storage, one byte (two nibbles) per entry. A byte never written
// since reset reads as two mid-scale nibbles.
// ----------------------------------------------------------------------------
module wsm_wave_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic             r_rd_valid;

    // Written bytes are tracked so reset needs no clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'h88;

endmodule

// ----- rtl/core/wavetable_sound_mixer_core.sv -----
// ----------------------------------------------------------------------------
// wavetable_sound_mixer_core
// Four-channel wavetable generator with channel 2 sweep, voice mix and
// master volume. Write words update tables and channel settings.
// ----------------------------------------------------------------------------
// Sequence: a write word is taken in idle and the core stays idle. A tick runs
// setup for each channel, then divide and accumulate for each active channel,
// then mix; mix waits while the previous output word is not taken.
// Throughput: one word at a time; the input is not ready during a tick.
// Reset: synchronous active low; registers go to their defaults and the wave
// table reads as mid-scale until written.
module wavetable_sound_mixer_core
    import wsm_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int WAVE_LEN     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: address[5:0], wdata[16:6], voice_sample[24:17], zero[31:25]
    input  logic [31:0] s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: left_sample[15:0], right_sample[31:16]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W     = $clog2(WAVE_LEN);
    localparam int BPC       = (WAVE_LEN + 1) / 2;
    localparam int MEM_DEPTH = NUM_CHANNELS * BPC;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Input word fields.
    logic [2:0]        w_req;
    logic [5:0]        w_addr;
    logic [FREQ_W-1:0] w_wdata;
    logic [7:0]        w_voice;

    assign w_req   = s_axis_tuser;
    assign w_addr  = s_axis_tdata[5:0];
    assign w_wdata = s_axis_tdata[16:6];
    assign w_voice = s_axis_tdata[24:17];

    // Configuration registers.
    logic [7:0]        r_master;
    logic              r_voice_en;
    logic              r_sweep_en;
    logic signed [7:0] r_sweep_step;
    logic [7:0]        r_sweep_period;

    // Channel state.
    logic              r_on    [NUM_CHANNELS];
    logic [FREQ_W-1:0] r_freq  [NUM_CHANNELS];
    logic [3:0]        r_lgain [NUM_CHANNELS];
    logic [3:0]        r_rgain [NUM_CHANNELS];
    logic [31:0]       r_phase [NUM_CHANNELS];
    logic [IDX_W-1:0]  r_last  [NUM_CHANNELS];
    logic signed [8:0] r_sweep_cnt;

    // Tick sequencer.
    t_state                r_state, n_state;
    logic [CH_W-1:0]       r_ch;
    logic [IDX_W-1:0]      r_idx;
    logic [7:0]            r_voice;
    logic signed [SUM_W-1:0] r_lsum, r_rsum;
    logic [31:0]           r_out_data;
    logic                  r_out_valid;

    logic                  w_accept;
    logic                  w_tick;
    logic                  w_last_ch;
    logic                  w_active;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [IDX_W-1:0]      w_div_index;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [7:0]            w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic                  w_mix_load;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_tick      = w_accept && (w_req == REQ_TICK);
    assign w_last_ch   = (r_ch == CH_W'(NUM_CHANNELS - 1));
    assign w_active    = r_on[r_ch] && !((r_ch == CH_W'(1)) && r_voice_en);

    // Divider operands for the current channel.
    assign w_dividend = DIVIDEND_W'(r_phase[r_ch]) * DIVIDEND_W'(TICK_SCALE);
    assign w_divisor  = DIVISOR_W'(FREQ_SPAN) - DIVISOR_W'(r_freq[r_ch]);

    // Wave table addressing.
    assign w_wr_en   = w_accept && (w_req == REQ_WAVE)
                       && (int'(w_addr[5:4]) < NUM_CHANNELS)
                       && (int'(w_addr[3:0]) * 2 + 1 < WAVE_LEN);
    assign w_wr_addr = AW'(int'(w_addr[5:4]) * BPC + int'(w_addr[3:0]));
    assign w_rd_addr = AW'(int'(r_ch) * BPC + int'(w_div_index >> 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_tick) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (w_active) begin
                    n_state = ST_DIV;
                end else if (w_last_ch) begin
                    n_state = ST_MIX;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = w_last_ch ? ST_MIX : ST_SETUP;
            end
            ST_MIX: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control strobes.
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_rd_en       = 1'b0;
        w_mix_load    = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SETUP: w_div_start   = w_active;
            ST_DIV:   w_rd_en       = w_div_done;
            ST_ACC:   ;
            ST_MIX:   w_mix_load    = !r_out_valid || m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master       <= 8'd80;
            r_voice_en     <= 1'b0;
            r_sweep_en     <= 1'b0;
            r_sweep_step   <= '0;
            r_sweep_period <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MASTER_VOLUME: r_master       <= i_cfg_data;
                CFG_VOICE_ENABLE:  r_voice_en     <= i_cfg_data[0];
                CFG_SWEEP_ENABLE:  r_sweep_en     <= i_cfg_data[0];
                CFG_SWEEP_STEP:    r_sweep_step   <= i_cfg_data;
                CFG_SWEEP_PERIOD:  r_sweep_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state: register writes, sweep on tick accept, phase update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_on[i]    <= 1'b0;
                r_freq[i]  <= '0;
                r_lgain[i] <= '0;
                r_rgain[i] <= '0;
                r_phase[i] <= '0;
                r_last[i]  <= '0;
            end
            r_sweep_cnt <= '0;
        end else begin
            if (w_accept) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (w_addr == 6'(i)) begin
                        case (w_req)
                            REQ_FREQ:   r_freq[i] <= w_wdata;
                            REQ_VOLUME: begin
                                r_lgain[i] <= w_wdata[7:4];
                                r_rgain[i] <= w_wdata[3:0];
                            end
                            REQ_ENABLE: r_on[i] <= w_wdata[0];
                            default: ;
                        endcase
                    end
                end
            end
            if (w_tick && r_sweep_en && (r_sweep_step != '0)) begin
                if (r_sweep_cnt < 0) begin
                    r_sweep_cnt <= $signed({1'b0, r_sweep_period}) - 9'sd1;
                    if (NUM_CHANNELS > 2) begin
                        r_freq[2 % NUM_CHANNELS] <= r_freq[2 % NUM_CHANNELS]
                                                    + FREQ_W'(r_sweep_step);
                    end
                end else begin
                    r_sweep_cnt <= r_sweep_cnt - 9'sd1;
                end
            end
            if (r_state == ST_ACC) begin
                r_last[r_ch] <= r_idx;
                if ((r_idx == '0) && (r_last[r_ch] != '0)) begin
                    r_phase[r_ch] <= 32'd1;
                end else begin
                    r_phase[r_ch] <= r_phase[r_ch] + 32'd1;
                end
            end
        end
    end

    // Per-channel sample value and its scaled contributions.
    logic [3:0]              w_nibble;
    logic signed [4:0]       w_value;
    logic signed [9:0]       w_lprod, w_rprod;

    always_comb begin
        w_nibble = r_idx[0] ? w_rd_data[7:4] : w_rd_data[3:0];
        w_value  = $signed({1'b0, w_nibble}) - 5'sd8;
        w_lprod  = w_value * $signed({1'b0, r_lgain[r_ch]});
        w_rprod  = w_value * $signed({1'b0, r_rgain[r_ch]});
    end

    // Final mix: voice term, then master volume.
    logic signed [SUM_W-1:0] w_vterm;
    logic signed [SUM_W-1:0] w_lmix, w_rmix;
    logic signed [SUM_W+8:0] w_lout, w_rout;

    always_comb begin
        w_vterm = r_voice_en ? SUM_W'($signed({1'b0, r_voice}) - 9'sd128) : '0;
        w_lmix  = r_lsum + w_vterm;
        w_rmix  = r_rsum + w_vterm;
        w_lout  = w_lmix * $signed({1'b0, r_master});
        w_rout  = w_rmix * $signed({1'b0, r_master});
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_voice <= w_voice;
            r_ch    <= '0;
            r_lsum  <= '0;
            r_rsum  <= '0;
        end
        if ((r_state == ST_SETUP) && !w_active && !w_last_ch) begin
            r_ch <= r_ch + 1'b1;
        end
        if (w_div_done && (r_state == ST_DIV)) begin
            r_idx <= w_div_index;
        end
        if (r_state == ST_ACC) begin
            r_lsum <= r_lsum + SUM_W'(w_lprod);
            r_rsum <= r_rsum + SUM_W'(w_rprod);
            if (!w_last_ch) begin
                r_ch <= r_ch + 1'b1;
            end
        end
        if (w_mix_load) begin
            r_out_data <= {w_rout[15:0], w_lout[15:0]};
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_mix_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    wsm_div #(
        .WAVE_LEN (WAVE_LEN),
        .IDX_W    (IDX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_index    (w_div_index)
    );

    wsm_wave_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_wave_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wdata[7:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule
